[hdl/spsq_pkg.sv]
// ----------------------------------------------------------------------------
// Stepper phase sequencer package
// Shared types, opcodes, reset values and coil pattern tables.
// ----------------------------------------------------------------------------
package spsq_pkg;

  localparam int unsigned IntervalW = 17;
  localparam int unsigned StepsW    = 16;
  localparam int unsigned CountW    = 32;
  localparam int unsigned PhaseW    = 3;
  localparam int unsigned CoilW     = 4;
  localparam int unsigned CfgIdxW   = 1;

  localparam logic [IntervalW-1:0] IntervalReset = IntervalW'(4000);
  localparam logic [IntervalW-1:0] ElapsedMax    = {IntervalW{1'b1}};

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_MOVE  = 3'd1,
    OP_RUN   = 3'd2,
    OP_STOP  = 3'd3,
    OP_CLEAR = 3'd4
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_STEP_INTERVAL = 1'b0,
    REG_HALF_STEP     = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [IntervalW-1:0] step_interval;
    logic                 half_step;
  } cfg_t;

  typedef struct packed {
    logic [PhaseW-1:0]    phase;
    logic                 dir;
    logic                 run;
    logic                 cont;
    logic [StepsW-1:0]    steps_left;
    logic [IntervalW-1:0] elapsed;
    logic [CountW-1:0]    count;
    logic [CoilW-1:0]     coil;
  } state_t;

  typedef struct packed {
    logic [CoilW-1:0]  coil_pattern;
    logic              motor_running;
    logic              step_taken;
    logic [PhaseW-1:0] phase_now;
    logic [CountW-1:0] total_steps_done;
  } result_t;

  function automatic logic [CoilW-1:0] half_coil(input logic [2:0] p);
    logic [CoilW-1:0] c;
    unique case (p)
      3'd0:    c = 4'b0001;
      3'd1:    c = 4'b0011;
      3'd2:    c = 4'b0010;
      3'd3:    c = 4'b0110;
      3'd4:    c = 4'b0100;
      3'd5:    c = 4'b1100;
      3'd6:    c = 4'b1000;
      default: c = 4'b1001;
    endcase
    return c;
  endfunction

  function automatic logic [CoilW-1:0] full_coil(input logic [1:0] p);
    logic [CoilW-1:0] c;
    unique case (p)
      2'd0:    c = 4'b0011;
      2'd1:    c = 4'b0110;
      2'd2:    c = 4'b1100;
      default: c = 4'b1001;
    endcase
    return c;
  endfunction

endpackage

[hdl/stepper_phase_sequencer.sv]
// ----------------------------------------------------------------------------
// Stepper phase sequencer
// Four-coil unipolar stepper driver with full-step and half-step tables.
// ----------------------------------------------------------------------------
// Each input transaction is either a one-microsecond tick or a command (move
// a number of steps, run continuously, stop, clear the step counter). Every
// input transaction yields exactly one output transaction carrying the coil
// drive pattern, the running flag, whether a step was taken, the phase index
// and the 32-bit step count, all as they stand after the transaction.
// Both channels use valid and stall. An input transaction is captured into
// an input register; once the output register is free, the step logic
// applies it to the motor state and the result is loaded into the output
// register, from which it is presented. One transaction can be accepted in
// every cycle while the receiver does not stall.
// When the receiver stalls, the output register holds its result; the input
// register drains into it as soon as the stall is released, so at most one
// further transaction is taken before the input side stalls too.
// Configuration writes (step interval, half-step mode) take effect at once.
// The user makes them only while the block is idle; it does not enforce this.
// A mode write restarts the phase at zero and leaves the coils as they are.
// Reset clears the motor state: coils off, phase zero, stopped, count zero,
// interval 4000 ticks, full-step mode.
// ----------------------------------------------------------------------------
module stepper_phase_sequencer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port
  input  logic                            cfg_we_i,
  input  logic [spsq_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [spsq_pkg::IntervalW-1:0]  cfg_data_i,
  // Input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [2:0]                      opcode_i,
  input  logic                            turn_direction_i,
  input  logic [spsq_pkg::StepsW-1:0]     step_total_i,
  // Output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [spsq_pkg::CoilW-1:0]      coil_pattern_o,
  output logic                            motor_running_o,
  output logic                            step_taken_o,
  output logic [spsq_pkg::PhaseW-1:0]     phase_now_o,
  output logic [spsq_pkg::CountW-1:0]     total_steps_done_o
);

  spsq_pkg::cfg_t    cfg;
  logic              phase_clr;
  spsq_pkg::state_t  state_q, state_d, state_nxt;
  spsq_pkg::result_t res, res_q;

  logic                        in_valid_q;
  logic [2:0]                  opcode_q;
  logic                        dir_q;
  logic [spsq_pkg::StepsW-1:0] total_q;
  logic                        out_valid_q;
  logic                        out_free;
  logic                        fire;
  logic                        in_take;

  spsq_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .phase_clr_o (phase_clr)
  );

  spsq_step u_step (
    .state_i          (state_q),
    .cfg_i            (cfg),
    .opcode_i         (opcode_q),
    .turn_direction_i (dir_q),
    .step_total_i     (total_q),
    .state_o          (state_nxt),
    .result_o         (res)
  );

  // The output register is free when empty or being emptied this cycle.
  assign out_free   = !out_valid_q || !out_stall_i;
  // The held transaction is applied to the state when it can move on.
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = fire ? state_nxt : state_q;
    if (phase_clr) begin
      state_d.phase = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Payload registers carry no reset; their valid bits qualify them.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      opcode_q <= opcode_i;
      dir_q    <= turn_direction_i;
      total_q  <= step_total_i;
    end
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign coil_pattern_o     = res_q.coil_pattern;
  assign motor_running_o    = res_q.motor_running;
  assign step_taken_o       = res_q.step_taken;
  assign phase_now_o        = res_q.phase_now;
  assign total_steps_done_o = res_q.total_steps_done;

  // A stopped motor always has its coils switched off.
  a_stopped_coils_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_q.run |-> (state_q.coil == '0))
    else $error("coils energised while the motor is stopped");

  // A continuous run never carries a remaining step count.
  a_cont_no_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.cont |-> (state_q.run && (state_q.steps_left == '0)))
    else $error("continuous run with steps outstanding");

  // A finite move that is still running has steps left to take.
  a_move_has_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.run && !state_q.cont) |-> (state_q.steps_left != '0))
    else $error("finite move running with no steps left");

  // The phase index stays inside the active table.
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg.half_step |-> (state_q.phase[2] == 1'b0))
    else $error("phase index outside the full-step table");

  // A step advances the step count by exactly one.
  a_step_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && res.step_taken) |=>
      (state_q.count == $past(state_q.count) + 1'b1))
    else $error("step taken without a single count increment");

endmodule

[hdl/spsq_cfg.sv]
// ----------------------------------------------------------------------------
// Stepper phase sequencer configuration registers
// Holds the step interval and the half-step mode bit.
// ----------------------------------------------------------------------------
module spsq_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [spsq_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [spsq_pkg::IntervalW-1:0]  cfg_data_i,
  output spsq_pkg::cfg_t                  cfg_o,
  output logic                            phase_clr_o
);

  spsq_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d       = cfg_q;
    phase_clr_o = 1'b0;
    if (cfg_we_i) begin
      unique case (spsq_pkg::cfg_reg_e'(cfg_idx_i))
        spsq_pkg::REG_STEP_INTERVAL: cfg_d.step_interval = cfg_data_i;
        spsq_pkg::REG_HALF_STEP: begin
          // A mode write restarts the phase in the new table.
          cfg_d.half_step = cfg_data_i[0];
          phase_clr_o     = 1'b1;
        end
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_interval <= spsq_pkg::IntervalReset;
      cfg_q.half_step     <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hdl/spsq_step.sv]
// ----------------------------------------------------------------------------
// Stepper phase sequencer step logic
// Applies one transaction to the motor state and forms its result.
// ----------------------------------------------------------------------------
module spsq_step (
  input  spsq_pkg::state_t               state_i,
  input  spsq_pkg::cfg_t                 cfg_i,
  input  logic [2:0]                     opcode_i,
  input  logic                           turn_direction_i,
  input  logic [spsq_pkg::StepsW-1:0]    step_total_i,
  output spsq_pkg::state_t               state_o,
  output spsq_pkg::result_t              result_o
);

  logic [spsq_pkg::IntervalW-1:0] elapsed_inc;
  logic [spsq_pkg::PhaseW-1:0]    len_last;
  logic [spsq_pkg::PhaseW-1:0]    phase_nxt;
  logic                           at_end;
  logic                           stepped;

  assign elapsed_inc = (state_i.elapsed < spsq_pkg::ElapsedMax) ?
                       state_i.elapsed + 1'b1 : state_i.elapsed;
  assign len_last    = cfg_i.half_step ? 3'd7 : 3'd3;

  always_comb begin
    at_end = (state_i.phase >= len_last);
    if (!state_i.dir) begin
      phase_nxt = at_end ? '0 : state_i.phase + 1'b1;
    end else begin
      phase_nxt = ((state_i.phase == '0) || (state_i.phase > len_last)) ?
                  len_last : state_i.phase - 1'b1;
    end
  end

  always_comb begin
    state_o = state_i;
    stepped = 1'b0;
    unique case (opcode_i)
      spsq_pkg::OP_TICK: begin
        if (state_i.run) begin
          state_o.elapsed = elapsed_inc;
          if (elapsed_inc >= cfg_i.step_interval) begin
            stepped         = 1'b1;
            state_o.phase   = phase_nxt;
            state_o.coil    = cfg_i.half_step ? spsq_pkg::half_coil(phase_nxt)
                                              : spsq_pkg::full_coil(phase_nxt[1:0]);
            state_o.count   = state_i.count + 1'b1;
            state_o.elapsed = '0;
            if (!state_i.cont && (state_i.steps_left != '0)) begin
              state_o.steps_left = state_i.steps_left - 1'b1;
              if (state_i.steps_left == spsq_pkg::StepsW'(1)) begin
                state_o.run  = 1'b0;
                state_o.cont = 1'b0;
                state_o.coil = '0;
              end
            end
          end
        end
      end
      spsq_pkg::OP_MOVE: begin
        if (step_total_i != '0) begin
          state_o.dir        = turn_direction_i;
          state_o.steps_left = step_total_i;
          state_o.cont       = 1'b0;
          state_o.run        = 1'b1;
          state_o.elapsed    = '0;
        end
      end
      spsq_pkg::OP_RUN: begin
        state_o.dir        = turn_direction_i;
        state_o.steps_left = '0;
        state_o.cont       = 1'b1;
        state_o.run        = 1'b1;
        state_o.elapsed    = '0;
      end
      spsq_pkg::OP_STOP: begin
        state_o.run        = 1'b0;
        state_o.cont       = 1'b0;
        state_o.steps_left = '0;
        state_o.coil       = '0;
      end
      spsq_pkg::OP_CLEAR: state_o.count = '0;
      default:            state_o = state_i;
    endcase
  end

  assign result_o.coil_pattern     = state_o.coil;
  assign result_o.motor_running    = state_o.run;
  assign result_o.step_taken       = stepped;
  assign result_o.phase_now        = state_o.phase;
  assign result_o.total_steps_done = state_o.count;

endmodule
